// ===== hdl/tmbc_pkg.sv =====
`timescale 1ns / 1ps

package tmbc_pkg;

	// fixed-point format of positions
	localparam int Q_FRAC = 8;
	localparam int Q_ONE = 256;
	localparam int POS_W = 24;
	// working width of a position between push steps
	localparam int WIDE_W = 28;
	// tile index field, wide enough for the largest map
	localparam int IDX_W = 10;
	localparam int CFG_W = 7;

	localparam logic [CFG_W-1:0] MAP_SIZE_RESET = 7'd64;

	// default geometry
	localparam int DEF_TILE_SIZE = 64;
	localparam int DEF_AGENT_SIZE = 60;
	localparam int DEF_MAX_COLUMNS = 64;
	localparam int DEF_MAX_ROWS = 64;

	// item kinds
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_RESOLVE = 1'b1;

	typedef enum logic {
		REG_MAP_COLUMNS = 1'b0,
		REG_MAP_ROWS    = 1'b1
	} cfg_reg_t;

	// classified item, as queued between front and back
	// write items use col[0], row[0] and col_ok[0] (tile inside storage)
	typedef struct packed {
		logic                    mode;
		logic                    solid;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [1:0][IDX_W-1:0]   col;
		logic [1:0][IDX_W-1:0]   row;
		logic [1:0]              col_ok;
		logic [1:0]              row_ok;
	} tile_req_t;

	// back to front control
	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

	typedef struct packed {
		logic                    hit;
		logic signed [POS_W-1:0] new_y;
		logic signed [POS_W-1:0] new_x;
	} res_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} back_state_t;

endpackage

// ===== hdl/tile_map_box_collision_resolve_core.sv =====
// Tile map collision resolver for a square agent.
// Input channel (push/full): mode 0 beats write one tile of the solid map,
// mode 1 beats give an agent position (pos_x, pos_y, signed Q16.8).
// Result channel (empty/pop): one beat per mode 1 item with the pushed-out
// position, saturated to 24 bits, and a hit flag. Write beats give none.
// Config: cfg_write with cfg_index 0 sets map_columns, 1 sets map_rows.
// Path: a resolve beat passes the request queue, the sequencer's run and
// done states and the result queue before its result is on the result ports.
// Pacing: a resolve is bound by the four corner reads of the single read
// port of the map memory, each followed by a dependent push step, and the
// next item starts only once it is done. A two-entry request queue sits
// between the front and the sequencer, a two-entry result queue after it.
// Reset: map sizes return to 64 and the map is cleared one tile per cycle,
// all MAX_COLUMNS * MAX_ROWS tiles (4096 by default), with full held high.
// Stall: when the result queue fills, the sequencer waits and then the
// request queue fills and full rises; no beat is lost.
// TILE_SIZE must be a power of two.
`timescale 1ns / 1ps

module tile_map_box_collision_resolve_core import tmbc_pkg::*; #(
	parameter int TILE_SIZE = DEF_TILE_SIZE,
	parameter int AGENT_SIZE = DEF_AGENT_SIZE,
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic                    mode,
	input  logic [5:0]              tile_column,
	input  logic [5:0]              tile_row,
	input  logic                    tile_solid,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [POS_W-1:0] new_x,
	output logic signed [POS_W-1:0] new_y,
	output logic                    hit,
	input  logic                    cfg_write,
	input  logic                    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	logic      head_valid;
	tile_req_t head;
	back_ctl_t ctl;

	tmbc_front #(
		.TILE_SIZE  (TILE_SIZE),
		.AGENT_SIZE (AGENT_SIZE),
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.tile_column(tile_column),
		.tile_row   (tile_row),
		.tile_solid (tile_solid),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head       (head),
		.ctl        (ctl)
	);

	tmbc_back #(
		.TILE_SIZE  (TILE_SIZE),
		.AGENT_SIZE (AGENT_SIZE),
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.ctl       (ctl),
		.res_pop   (pop),
		.res_empty (empty),
		.new_x     (new_x),
		.new_y     (new_y),
		.hit       (hit)
	);

endmodule

// ===== hdl/tmbc_ram.sv =====
`timescale 1ns / 1ps

module tmbc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/tmbc_fifo.sv =====
`timescale 1ns / 1ps

module tmbc_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign do_wr = wr_en & ~full;
	assign do_rd = rd_en & ~empty;
	assign rd_data = mem_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wptr_q <= ~wptr_q;
			end
			if (do_rd) begin
				rptr_q <= ~rptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule

// ===== hdl/tmbc_front.sv =====
`timescale 1ns / 1ps

module tmbc_front import tmbc_pkg::*; #(
	parameter int TILE_SIZE = DEF_TILE_SIZE,
	parameter int AGENT_SIZE = DEF_AGENT_SIZE,
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic                    mode,
	input  logic [5:0]              tile_column,
	input  logic [5:0]              tile_row,
	input  logic                    tile_solid,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic                    cfg_write,
	input  logic                    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output logic                    head_valid,
	output tile_req_t               head,
	input  back_ctl_t               ctl
);

	// corner coordinates need room for the agent offset
	localparam int EW = POS_W + 2;
	localparam int TSH = $clog2(TILE_SIZE) + Q_FRAC;
	localparam logic signed [EW-1:0] AGENT_Q = EW'(AGENT_SIZE * Q_ONE);

	logic [CFG_W-1:0]       map_columns_q;
	logic [CFG_W-1:0]       map_rows_q;
	logic signed [EW-1:0]   cx [2];
	logic signed [EW-1:0]   cy [2];
	logic signed [EW-1:0]   ix [2];
	logic signed [EW-1:0]   iy [2];
	tile_req_t              req;
	logic [$bits(tile_req_t)-1:0] head_vec;
	logic                   q_full;
	logic                   q_empty;
	logic                   accept;

	// map size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_columns_q <= MAP_SIZE_RESET;
			map_rows_q <= MAP_SIZE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MAP_COLUMNS: map_columns_q <= cfg_data;
				REG_MAP_ROWS:    map_rows_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// corner tiles: two columns and two rows cover all four corners
	always_comb begin
		cx[0] = EW'(pos_x);
		cx[1] = EW'(pos_x) + AGENT_Q;
		cy[0] = EW'(pos_y);
		cy[1] = EW'(pos_y) + AGENT_Q;
		req = '0;
		req.mode = mode;
		req.solid = tile_solid;
		req.x = pos_x;
		req.y = pos_y;
		for (int j = 0; j < 2; j++) begin
			ix[j] = cx[j] >>> TSH;
			iy[j] = cy[j] >>> TSH;
			req.col[j] = ix[j][IDX_W-1:0];
			req.row[j] = iy[j][IDX_W-1:0];
			req.col_ok[j] = !ix[j][EW-1]
				&& ($unsigned(ix[j]) < EW'(map_columns_q))
				&& ($unsigned(ix[j]) < EW'(MAX_COLUMNS));
			req.row_ok[j] = !iy[j][EW-1]
				&& ($unsigned(iy[j]) < EW'(map_rows_q))
				&& ($unsigned(iy[j]) < EW'(MAX_ROWS));
		end
		// tile write: reuse the first column and row slots
		if (mode == MODE_WRITE) begin
			req.col[0] = IDX_W'(tile_column);
			req.row[0] = IDX_W'(tile_row);
			req.col_ok[0] = (32'(tile_column) < 32'(MAX_COLUMNS))
				&& (32'(tile_row) < 32'(MAX_ROWS));
		end
	end

	// no item taken while the map is being cleared
	assign full = q_full | ctl.clearing;
	assign accept = push & ~full;

	tmbc_fifo #(
		.WIDTH($bits(tile_req_t))
	) u_req_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wr_data(req),
		.full   (q_full),
		.rd_en  (ctl.pop),
		.rd_data(head_vec),
		.empty  (q_empty)
	);

	assign head = tile_req_t'(head_vec);
	assign head_valid = ~q_empty;

endmodule

// ===== hdl/tmbc_back.sv =====
`timescale 1ns / 1ps

module tmbc_back import tmbc_pkg::*; #(
	parameter int TILE_SIZE = DEF_TILE_SIZE,
	parameter int AGENT_SIZE = DEF_AGENT_SIZE,
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  tile_req_t               head,
	output back_ctl_t               ctl,
	input  logic                    res_pop,
	output logic                    res_empty,
	output logic signed [POS_W-1:0] new_x,
	output logic signed [POS_W-1:0] new_y,
	output logic                    hit
);

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TSH = $clog2(TILE_SIZE) + Q_FRAC;
	localparam logic signed [WIDE_W-1:0] AGENT_HALF = WIDE_W'(AGENT_SIZE * (Q_ONE / 2));
	localparam logic signed [WIDE_W-1:0] TILE_HALF = WIDE_W'(TILE_SIZE * (Q_ONE / 2));
	localparam logic signed [WIDE_W-1:0] MIN_DIST =
		WIDE_W'((AGENT_SIZE + TILE_SIZE) * (Q_ONE / 2));
	localparam logic signed [WIDE_W-1:0] POS_HI = WIDE_W'(8388607);
	localparam logic signed [WIDE_W-1:0] POS_LO = WIDE_W'(-8388608);

	back_state_t              state_q;
	back_state_t              state_d;
	logic [1:0]               cnt_q;
	logic [AW-1:0]            clr_addr_q;
	tile_req_t                work_q;
	logic signed [WIDE_W-1:0] px_q;
	logic signed [WIDE_W-1:0] py_q;
	logic                     hit_q;

	logic                     start;
	logic                     start_res;
	logic                     start_wr;
	logic                     res_full;
	logic                     res_push;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic                     ram_wdata;
	logic [AW-1:0]            ram_raddr;
	logic                     ram_rdata;
	logic [1:0]               nk;

	logic                     csel;
	logic                     rsel;
	logic                     solid;
	logic signed [WIDE_W-1:0] cen_x;
	logic signed [WIDE_W-1:0] cen_y;
	logic signed [WIDE_W-1:0] dx;
	logic signed [WIDE_W-1:0] dy;
	logic signed [WIDE_W-1:0] xd;
	logic signed [WIDE_W-1:0] yd;
	logic signed [WIDE_W-1:0] px_n;
	logic signed [WIDE_W-1:0] py_n;

	res_t                     res_in;
	res_t                     res_out;
	logic [$bits(res_t)-1:0]  res_vec;

	function automatic logic [AW-1:0] tile_addr(input logic [IDX_W-1:0] c,
		input logic [IDX_W-1:0] r);
		return AW'(int'(r) * MAX_COLUMNS + int'(c));
	endfunction

	function automatic logic signed [POS_W-1:0] sat(input logic signed [WIDE_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > POS_HI) begin
			r = POS_HI[POS_W-1:0];
		end else if (v < POS_LO) begin
			r = POS_LO[POS_W-1:0];
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

	// a new queue entry can start once the previous result is handed off
	assign start = head_valid
		& ((state_q == ST_IDLE) | ((state_q == ST_DONE) & ~res_full));
	assign start_res = start & (head.mode == MODE_RESOLVE);
	assign start_wr = start & (head.mode == MODE_WRITE);
	assign nk = cnt_q + 2'd1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start_res) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cnt_q == 2'd3) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!res_full) begin
					state_d = start_res ? ST_RUN : ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// outputs: map port, queue pop, result push
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = tile_addr(head.col[0], head.row[0]);
		ram_wdata = head.solid;
		ram_raddr = tile_addr(work_q.col[nk[0]], work_q.row[nk[1]]);
		ctl.pop = 1'b0;
		ctl.clearing = 1'b0;
		res_push = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = 1'b0;
				ctl.clearing = 1'b1;
			end
			ST_IDLE: begin
				ctl.pop = start;
				ram_we = start_wr & head.col_ok[0];
				ram_raddr = tile_addr(head.col[0], head.row[0]);
			end
			ST_RUN: begin
			end
			ST_DONE: begin
				res_push = ~res_full;
				ctl.pop = start;
				ram_we = start_wr & head.col_ok[0];
				ram_raddr = tile_addr(head.col[0], head.row[0]);
			end
			default: begin
			end
		endcase
	end

	// push-out step for the corner whose map bit is arriving
	always_comb begin
		csel = cnt_q[0];
		rsel = cnt_q[1];
		solid = ram_rdata & work_q.col_ok[csel] & work_q.row_ok[rsel];
		cen_x = signed'(WIDE_W'(work_q.col[csel]) << TSH) + TILE_HALF;
		cen_y = signed'(WIDE_W'(work_q.row[rsel]) << TSH) + TILE_HALF;
		dx = px_q + AGENT_HALF - cen_x;
		dy = py_q + AGENT_HALF - cen_y;
		xd = MIN_DIST - ((dx < 0) ? -dx : dx);
		yd = MIN_DIST - ((dy < 0) ? -dy : dy);
		px_n = px_q;
		py_n = py_q;
		if (solid && (xd > 0) && (yd > 0)) begin
			if (xd < yd) begin
				px_n = px_q + ((dx < 0) ? -xd : xd);
			end else begin
				py_n = py_q + ((dy < 0) ? -yd : yd);
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= 2'd0;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (start_res) begin
				cnt_q <= 2'd0;
			end else if (state_q == ST_RUN) begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	// working position
	always_ff @(posedge clk) begin
		if (start_res) begin
			work_q <= head;
			px_q <= WIDE_W'(head.x);
			py_q <= WIDE_W'(head.y);
			hit_q <= 1'b0;
		end else if (state_q == ST_RUN) begin
			px_q <= px_n;
			py_q <= py_n;
			hit_q <= hit_q | solid;
		end
	end

	tmbc_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// result queue
	always_comb begin
		res_in.hit = hit_q;
		res_in.new_x = sat(px_q);
		res_in.new_y = sat(py_q);
	end

	tmbc_fifo #(
		.WIDTH($bits(res_t))
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (res_pop),
		.rd_data(res_vec),
		.empty  (res_empty)
	);

	assign res_out = res_t'(res_vec);
	assign new_x = res_out.new_x;
	assign new_y = res_out.new_y;
	assign hit = res_out.hit;

`ifndef SYNTH
	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clearing |-> !ctl.pop)
		else $error("queue popped during map clear");

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> head_valid)
		else $error("pop with empty request queue");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cnt_q == 2'd3) |=> (state_q == ST_DONE))
		else $error("resolve did not finish after four corners");

	a_push_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (state_q == ST_DONE && !res_full))
		else $error("result pushed outside done state or into full queue");
`endif

endmodule
